@@ rtl/core/bgra_premul_to_rgba_straight_core_assert.svh @@
// assertion macros used by the checker file
`ifndef BGRA_PREMUL_TO_RGBA_STRAIGHT_CORE_ASSERT_SVH
`define BGRA_PREMUL_TO_RGBA_STRAIGHT_CORE_ASSERT_SVH

// property that must hold at every edge out of reset
`define BPRS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bprs assertion failed");

// overlapping implication
`define BPRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bprs implication failed");

`endif

@@ rtl/core/bprs_pkg.sv @@
package bprs_pkg;

    localparam int CHAN_W      = 8;
    localparam int WORK_W      = 2 * CHAN_W;
    localparam int QUOT_BITS   = CHAN_W;
    localparam int STAGE_STEPS = 2;
    localparam int DIV_STAGES  = QUOT_BITS / STAGE_STEPS;
    // numerator stage, divider stages, output select stage
    localparam int LATENCY     = DIV_STAGES + 2;

    localparam logic [CHAN_W-1:0] CHAN_MAX  = '1;
    localparam logic [CHAN_W-1:0] ALPHA_ZERO = '0;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [WORK_W-1:0] work_t;

    // one restoring step: upper half is the partial remainder, lower half shifts
    // numerator bits out and quotient bits in
    function automatic work_t div_step(input work_t w, input chan_t d);
        logic [CHAN_W:0] t;
        work_t           r;
        t = {w[WORK_W-1:CHAN_W], w[CHAN_W-1]};
        if (t >= {1'b0, d})
        begin
            r = {CHAN_W'(t - {1'b0, d}), w[CHAN_W-2:0], 1'b1};
        end
        else
        begin
            r = {t[CHAN_W-1:0], w[CHAN_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/bgra_premul_to_rgba_straight_core.sv @@
// channel  | direction | handshake         | fields
// pixel in | in        | start, busy       | blue_in, green_in, red_in, alpha_in
// pixel out| out       | done (one cycle)  | red_out, green_out, blue_out, alpha_out
//
// one pixel per clock; done is start delayed through the valid register chain
// pipeline: one numerator stage, four stages of a restoring divider at two
// quotient bits each, one output select stage
// busy never rises: the pipeline has no stall point
// rst_n clears the valid bits only; data registers run free
module bgra_premul_to_rgba_straight_core
    import bprs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  chan_t blue_in,
    input  chan_t green_in,
    input  chan_t red_in,
    input  chan_t alpha_in,
    output logic  done,
    output chan_t red_out,
    output chan_t green_out,
    output chan_t blue_out,
    output chan_t alpha_out
);

    logic  accept;
    logic  valid_reg [LATENCY];
    chan_t alpha_reg [LATENCY];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LATENCY; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int s = 1; s < LATENCY; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg[0] <= alpha_in;
        for (int s = 1; s < LATENCY; s++)
        begin
            alpha_reg[s] <= alpha_reg[s-1];
        end
    end

    bprs_lane u_red
    (
        .clk    (clk),
        .color  (red_in),
        .alpha  (alpha_in),
        .result (red_out)
    );

    bprs_lane u_green
    (
        .clk    (clk),
        .color  (green_in),
        .alpha  (alpha_in),
        .result (green_out)
    );

    bprs_lane u_blue
    (
        .clk    (clk),
        .color  (blue_in),
        .alpha  (alpha_in),
        .result (blue_out)
    );

    assign done      = valid_reg[LATENCY-1];
    assign alpha_out = alpha_reg[LATENCY-1];

endmodule

@@ rtl/core/bprs_lane.sv @@
module bprs_lane
    import bprs_pkg::*;
(
    input  logic  clk,
    input  chan_t color,
    input  chan_t alpha,
    output chan_t result
);

    work_t work_reg  [DIV_STAGES+1];
    work_t work_next [DIV_STAGES+1];
    chan_t div_reg   [DIV_STAGES];
    chan_t color_reg [DIV_STAGES+1];
    logic  pass_reg  [DIV_STAGES+1];
    logic  sat_reg   [DIV_STAGES+1];
    chan_t result_reg;
    chan_t result_next;

    // color*255 + alpha/2; a color at or above alpha saturates unless alpha is 0 or 255, which pass the color
    always_comb
    begin
        work_next[0] = {color, {CHAN_W{1'b0}}} - WORK_W'(color) + WORK_W'(alpha[CHAN_W-1:1]);
    end

    always_ff @(posedge clk)
    begin
        work_reg[0]  <= work_next[0];
        div_reg[0]   <= alpha;
        color_reg[0] <= color;
        pass_reg[0]  <= (alpha == ALPHA_ZERO) || (alpha == CHAN_MAX);
        sat_reg[0]   <= (color >= alpha);
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_div
        always_comb
        begin
            work_next[s] = work_reg[s-1];
            for (int k = 0; k < STAGE_STEPS; k++)
            begin
                work_next[s] = div_step(work_next[s], div_reg[s-1]);
            end
        end

        always_ff @(posedge clk)
        begin
            work_reg[s]  <= work_next[s];
            color_reg[s] <= color_reg[s-1];
            pass_reg[s]  <= pass_reg[s-1];
            sat_reg[s]   <= sat_reg[s-1];
        end

        // the divisor is only needed up to the last divider stage
        if (s < DIV_STAGES)
        begin : g_div_fwd
            always_ff @(posedge clk)
            begin
                div_reg[s] <= div_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (pass_reg[DIV_STAGES])
        begin
            result_next = color_reg[DIV_STAGES];
        end
        else if (sat_reg[DIV_STAGES])
        begin
            result_next = CHAN_MAX;
        end
        else
        begin
            result_next = work_reg[DIV_STAGES][CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

@@ rtl/core/bprs_checker.sv @@
`include "bgra_premul_to_rgba_straight_core_assert.svh"

module bprs_checker
    import bprs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input chan_t blue_in,
    input chan_t green_in,
    input chan_t red_in,
    input chan_t alpha_in,
    input logic  done,
    input chan_t red_out,
    input chan_t green_out,
    input chan_t blue_out,
    input chan_t alpha_out
);

    // every accepted item comes out exactly once, and done rises for no other
    `BPRS_ASSERT_ALWAYS(a_done_latency, clk, rst_n,
        done == $past(start && !busy && rst_n, LATENCY))

    `BPRS_ASSERT_IMPLY(a_alpha_pass, clk, rst_n, done,
        alpha_out == $past(alpha_in, LATENCY))

    // opaque pixels keep their red and blue, transparent pixels their green and red
    `BPRS_ASSERT_IMPLY(a_opaque_pass, clk, rst_n, done && (alpha_out == CHAN_MAX),
        (red_out == $past(red_in, LATENCY)) && (blue_out == $past(blue_in, LATENCY)))

    `BPRS_ASSERT_IMPLY(a_clear_pass, clk, rst_n, done && (alpha_out == ALPHA_ZERO),
        (green_out == $past(green_in, LATENCY)) && (red_out == $past(red_in, LATENCY)))

endmodule

bind bgra_premul_to_rgba_straight_core bprs_checker u_bprs_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;
    import bprs_pkg::*;

    localparam int RAND_PIXELS = 1930;
    localparam int CALM_TAIL   = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
        chan_t a;
    } rgba_t;

    // b, g, r, a in; typed flag; expected r, g, b
    typedef struct packed {
        chan_t b;
        chan_t g;
        chan_t r;
        chan_t a;
        logic  typed;
        chan_t er;
        chan_t eg;
        chan_t eb;
    } pixel_row_t;

    localparam int N_ROWS = 18;
    localparam pixel_row_t PIXEL_ROWS [N_ROWS] = '{
        // fully transparent: colors pass through
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd12,  8'd34,  8'd56,  8'd0,   1'b1, 8'd56,  8'd34,  8'd12},
        // opaque: colors pass through
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd10,  8'd200, 8'd99,  8'd255, 1'b1, 8'd99,  8'd200, 8'd10},
        // smallest alpha
        '{8'd0,   8'd0,   8'd0,   8'd1,   1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd1,   8'd1,   8'd1,   8'd1,   1'b1, 8'd255, 8'd255, 8'd255},
        // color above alpha saturates
        '{8'd255, 8'd128, 8'd200, 8'd10,  1'b1, 8'd255, 8'd255, 8'd255},
        // largest divided alpha, then other alphas with expected values from unpremul_pixel
        '{8'd254, 8'd254, 8'd254, 8'd254, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd0,   8'd0,   8'd0,   8'd254, 1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd1,   8'd2,   8'd3,   8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd64,  8'd128, 8'd192, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd50,  8'd100, 8'd150, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd1,   8'd0,   8'd127, 8'd2,   1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd100, 8'd100, 8'd100, 8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd170, 8'd85,  8'd255, 8'd170, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd0,   8'd0,   8'd127, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    chan_t blue_in;
    chan_t green_in;
    chan_t red_in;
    chan_t alpha_in;
    logic  done;
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    chan_t alpha_out;

    rgba_t       straight_q[$];
    rgba_t       want;
    logic        row_typed;
    rgba_t       row_want;
    int          err_cnt;
    int unsigned cycle_cnt;

    bgra_premul_to_rgba_straight_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .blue_in   (blue_in),
        .green_in  (green_in),
        .red_in    (red_in),
        .alpha_in  (alpha_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic chan_t unpremul_chan(input chan_t c, input chan_t a);
        int unsigned q;
        if (a == ALPHA_ZERO || a == CHAN_MAX)
        begin
            return c;
        end
        q = (int'(c) * 255 + (int'(a) >> 1)) / int'(a);
        return (q > 255) ? CHAN_MAX : chan_t'(q);
    endfunction

    function automatic rgba_t unpremul_pixel(input chan_t b, input chan_t g,
                                             input chan_t r, input chan_t a);
        rgba_t p;
        p.r = unpremul_chan(r, a);
        p.g = unpremul_chan(g, a);
        p.b = unpremul_chan(b, a);
        p.a = a;
        return p;
    endfunction

    task automatic check_chan(input string name, input chan_t exp_v, input chan_t act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // compare results and record accepted items at the rising edge
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("bgra_premul_to_rgba_straight_core test failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (straight_q.size() == 0)
                begin
                    $error("result with no pixel pending");
                    err_cnt++;
                end
                else
                begin
                    want = straight_q.pop_front();
                    check_chan("red_out", want.r, red_out);
                    check_chan("green_out", want.g, green_out);
                    check_chan("blue_out", want.b, blue_out);
                    check_chan("alpha_out", want.a, alpha_out);
                end
            end
            if (start && !busy)
            begin
                if (row_typed)
                begin
                    straight_q.push_back(row_want);
                end
                else
                begin
                    straight_q.push_back(unpremul_pixel(blue_in, green_in, red_in, alpha_in));
                end
            end
        end
    end

    task automatic send_pixel(input chan_t b, input chan_t g, input chan_t r, input chan_t a,
                              input logic typed, input rgba_t typed_want);
        @(negedge clk);
        start     <= 1'b1;
        blue_in   <= b;
        green_in  <= g;
        red_in    <= r;
        alpha_in  <= a;
        row_typed <= typed;
        row_want  <= typed_want;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start     <= 1'b0;
            blue_in   <= chan_t'($urandom);
            green_in  <= chan_t'($urandom);
            red_in    <= chan_t'($urandom);
            alpha_in  <= chan_t'($urandom);
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (straight_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_pixel();
        int    kind;
        chan_t a;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            // well-formed premultiplied data
            a = chan_t'($urandom_range(1, 254));
            send_pixel(chan_t'($urandom_range(0, a)), chan_t'($urandom_range(0, a)),
                       chan_t'($urandom_range(0, a)), a, 1'b0, '0);
        end
        else
        begin
            case (kind)
                6: a = ALPHA_ZERO;
                7: a = CHAN_MAX;
                8: a = chan_t'($urandom);
                default: a = chan_t'($urandom_range(1, 4));
            endcase
            send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), a, 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        blue_in   = '0;
        green_in  = '0;
        red_in    = '0;
        alpha_in  = '0;
        row_typed = 1'b0;
        row_want  = '0;
        err_cnt   = 0;
        cycle_cnt = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (PIXEL_ROWS[i])
        begin
            send_pixel(PIXEL_ROWS[i].b, PIXEL_ROWS[i].g, PIXEL_ROWS[i].r, PIXEL_ROWS[i].a,
                       PIXEL_ROWS[i].typed,
                       '{PIXEL_ROWS[i].er, PIXEL_ROWS[i].eg, PIXEL_ROWS[i].eb, PIXEL_ROWS[i].a});
        end
        wait_drained();

        for (int i = 0; i < RAND_PIXELS; i++)
        begin
            if (i == RAND_PIXELS / 2)
            begin
                wait_drained();
            end
            // no gaps in the tail so the pipeline runs back to back
            if (i < RAND_PIXELS - CALM_TAIL && $urandom_range(0, 3) == 0)
            begin
                idle_cycles($urandom_range(1, 11));
            end
            send_random_pixel();
        end

        wait_drained();
        repeat (LATENCY + 4) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("bgra_premul_to_rgba_straight_core test passed");
        end
        else
        begin
            $display("bgra_premul_to_rgba_straight_core test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bprs_pkg.sv
rtl/core/bprs_lane.sv
rtl/core/bgra_premul_to_rgba_straight_core.sv
rtl/core/bprs_checker.sv
tb/tb_top.sv
